// ===== design/mbrfe_pkg.sv =====
// mbrfe_pkg: shared types, constants and functions of the modbus request frame encoder
// request item struct, frame byte selection and crc-16/modbus byte fold
// no dependencies
package mbrfe_pkg;

	localparam int HDR_LEN   = 6;
	localparam int FRAME_LEN = 8;
	localparam int BYTE_IDX_W = $clog2(FRAME_LEN);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic [7:0]  slave_address;
		logic [7:0]  function_code;
		logic [15:0] register_address;
		logic [15:0] count_or_value;
	} req_t;

	// header bytes of the frame in transmit order
	function automatic logic [7:0] frame_byte(input req_t r, input logic [BYTE_IDX_W-1:0] k);
		logic [7:0] b;
		case (k)
			3'd0: b = r.slave_address;
			3'd1: b = r.function_code;
			3'd2: b = r.register_address[15:8];
			3'd3: b = r.register_address[7:0];
			3'd4: b = r.count_or_value[15:8];
			3'd5: b = r.count_or_value[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// reflected crc, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int j = 0; j < 8; j++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== design/modbus_request_frame_encoder_unit.sv =====
// modbus_request_frame_encoder_unit: modbus rtu request frame encoder top level
// uses mbrfe_pkg, mbrfe_crc_pipe, mbrfe_serializer
//
// input channel (in_valid / in_stall) takes one request item: slave address,
// function code, register address and count or value. output channel
// (out_valid / out_stall) gives the eight frame bytes one item per cycle
// while out_stall is low: address, function, register hi/lo, count hi/lo,
// crc lo, crc hi. last_byte is high on the eighth byte. the crc is
// crc-16/modbus over the first six bytes, one byte folded per pipeline stage.
//
// a request passes the six crc stages and then the output shift register
// before its first byte appears. the single byte-wide output sends one frame
// at a time and loads the next as the last byte of the previous one leaves.
// the crc pipeline can take a request every cycle while its first stage can
// move and buffers up to six. a stall on the output holds the current byte and
// fills the pipeline, after which in_stall rises; nothing is lost or repeated.
// reset (arst_n low) empties all stages; no data state is kept.
module modbus_request_frame_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  slave_address,
	input  logic [7:0]  function_code,
	input  logic [15:0] register_address,
	input  logic [15:0] count_or_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        last_byte
);
	import mbrfe_pkg::*;

	req_t        in_req;
	req_t        pipe_req;
	logic [15:0] pipe_crc;
	logic        pipe_valid;
	logic        pipe_stall;

	assign in_req = '{slave_address:    slave_address,
	                  function_code:    function_code,
	                  register_address: register_address,
	                  count_or_value:   count_or_value};

	mbrfe_crc_pipe u_crc_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (pipe_valid),
		.out_stall (pipe_stall),
		.out_req   (pipe_req),
		.out_crc   (pipe_crc)
	);

	mbrfe_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pipe_valid),
		.in_stall  (pipe_stall),
		.in_req    (pipe_req),
		.in_crc    (pipe_crc),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte   (tx_byte),
		.last_byte (last_byte)
	);

endmodule

// ===== design/mbrfe_crc_pipe.sv =====
// mbrfe_crc_pipe: six-stage crc pipeline, one header byte folded per stage
// uses mbrfe_pkg (req_t, frame_byte, crc_byte)
module mbrfe_crc_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mbrfe_pkg::req_t    in_req,
	output logic               out_valid,
	input  logic               out_stall,
	output mbrfe_pkg::req_t    out_req,
	output logic [15:0]        out_crc
);
	import mbrfe_pkg::*;

	// index 0 is the input side, 1..HDR_LEN are the stage registers
	logic        vld_s [0:HDR_LEN];
	req_t        req_s [0:HDR_LEN];
	logic [15:0] crc_s [0:HDR_LEN];
	logic        adv   [0:HDR_LEN];

	assign vld_s[0] = in_valid;
	assign req_s[0] = in_req;
	assign crc_s[0] = CRC_INIT;

	// a stage moves when it is empty or the next one moves
	assign adv[HDR_LEN] = !out_stall;

	for (genvar i = 0; i < HDR_LEN; i++) begin : g_stage
		assign adv[i] = !vld_s[i+1] || adv[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv[i]) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[i] && vld_s[i]) begin
				req_s[i+1] <= req_s[i];
				crc_s[i+1] <= crc_byte(crc_s[i], frame_byte(req_s[i], BYTE_IDX_W'(i)));
			end
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_s[HDR_LEN];
	assign out_req   = req_s[HDR_LEN];
	assign out_crc   = crc_s[HDR_LEN];

endmodule

// ===== design/mbrfe_serializer.sv =====
// mbrfe_serializer: loads a finished request and its crc, sends the eight frame bytes
// uses mbrfe_pkg (req_t, frame_byte, FRAME_LEN)
module mbrfe_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mbrfe_pkg::req_t    in_req,
	input  logic [15:0]        in_crc,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         tx_byte,
	output logic               last_byte
);
	import mbrfe_pkg::*;

	logic [8*FRAME_LEN-1:0] frame_q;
	logic [BYTE_IDX_W-1:0]  idx_q;
	logic                   busy_q;
	logic                   out_take;
	logic                   is_last;
	logic                   load;

	assign is_last  = (idx_q == BYTE_IDX_W'(FRAME_LEN - 1));
	assign out_take = busy_q && !out_stall;
	// a new frame loads as the last byte of the previous one leaves
	assign in_stall = busy_q && !(is_last && !out_stall);
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_take) begin
			idx_q <= idx_q + 1'b1;
			if (is_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= {frame_byte(in_req, 3'd0), frame_byte(in_req, 3'd1),
			            frame_byte(in_req, 3'd2), frame_byte(in_req, 3'd3),
			            frame_byte(in_req, 3'd4), frame_byte(in_req, 3'd5),
			            in_crc[7:0], in_crc[15:8]};
		end else if (out_take) begin
			frame_q <= {frame_q[8*FRAME_LEN-9:0], 8'h00};
		end
	end

	assign out_valid = busy_q;
	assign tx_byte   = frame_q[8*FRAME_LEN-1 -: 8];
	assign last_byte = is_last;

endmodule

// ===== design/mbrfe_checker.sv =====
// mbrfe_checker: port-level assertions for the modbus request frame encoder
// bound to modbus_request_frame_encoder_unit; uses mbrfe_pkg (FRAME_LEN, HDR_LEN)
module mbrfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  tx_byte,
	input logic        last_byte
);
	import mbrfe_pkg::*;

	logic       in_take;
	logic       out_take;
	logic [2:0] byte_cnt_q;
	logic [3:0] pending_q;

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	// bytes sent in the current frame and items accepted but not fully sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			pending_q  <= '0;
		end else begin
			if (out_take) begin
				byte_cnt_q <= byte_cnt_q + 1'b1;
			end
			pending_q <= pending_q + {3'd0, in_take} - {3'd0, out_take && last_byte};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(last_byte))
		else $error("stalled output byte changed");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_byte == (byte_cnt_q == 3'(FRAME_LEN - 1))))
		else $error("last_byte not on the eighth byte of a frame");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("output byte without a pending request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'(HDR_LEN + 1))
		else $error("more requests in flight than the pipeline holds");

endmodule

bind modbus_request_frame_encoder_unit mbrfe_checker u_mbrfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.tx_byte   (tx_byte),
	.last_byte (last_byte)
);

// ===== dv/tb_modbus_request_frame_encoder_unit.sv =====
// tb_modbus_request_frame_encoder_unit: self-checking testbench of the modbus rtu request encoder
// predicts the eight frame bytes and the crc-16/modbus of every request, with random idling
// depends on mbrfe_pkg and modbus_request_frame_encoder_unit
module tb_modbus_request_frame_encoder_unit;

	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} tx_item_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  slave_address;
	logic [7:0]  function_code;
	logic [15:0] register_address;
	logic [15:0] count_or_value;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  tx_byte;
	logic        last_byte;

	tx_item_t frame_bytes_q[$];
	int       errors;
	int       in_gap_pct;
	int       out_stall_pct;
	int       stall_left;

	modbus_request_frame_encoder_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.slave_address    (slave_address),
		.function_code    (function_code),
		.register_address (register_address),
		.count_or_value   (count_or_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.tx_byte          (tx_byte),
		.last_byte        (last_byte)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [15:0] fold_crc(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_REFLECTED_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	// queues the eight bytes the request must turn into, in transmit order
	function automatic void encode_request(input mbrfe_pkg::req_t r);
		logic [7:0]  hdr[6];
		logic [15:0] crc;
		tx_item_t    t;
		hdr[0] = r.slave_address;
		hdr[1] = r.function_code;
		hdr[2] = r.register_address[15:8];
		hdr[3] = r.register_address[7:0];
		hdr[4] = r.count_or_value[15:8];
		hdr[5] = r.count_or_value[7:0];
		crc = CRC_SEED;
		for (int i = 0; i < 6; i++) begin
			crc = fold_crc(crc, hdr[i]);
			t.data = hdr[i];
			t.last = 1'b0;
			frame_bytes_q.push_back(t);
		end
		t.data = crc[7:0];
		t.last = 1'b0;
		frame_bytes_q.push_back(t);
		t.data = crc[15:8];
		t.last = 1'b1;
		frame_bytes_q.push_back(t);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
	endtask

	// called at a rising edge; returns at the edge where the item was taken, valid still high
	task automatic send_request(input logic [7:0] addr, input logic [7:0] fc,
			input logic [15:0] reg_addr, input logic [15:0] cnt);
		int              gap;
		logic            taken;
		mbrfe_pkg::req_t r;
		gap = pick_gap(in_gap_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		slave_address <= addr;
		function_code <= fc;
		register_address <= reg_addr;
		count_or_value <= cnt;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		r.slave_address = addr;
		r.function_code = fc;
		r.register_address = reg_addr;
		r.count_or_value = cnt;
		encode_request(r);
	endtask

	task automatic send_random_request(input bit well_formed);
		logic [7:0]  fc;
		logic [15:0] cnt;
		if (!well_formed) begin
			send_request(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
		end else begin
			fc = $urandom_range(0, 1) ? FC_READ_HOLDING : FC_WRITE_SINGLE;
			cnt = (fc == FC_READ_HOLDING) ? 16'($urandom_range(1, 125)) : 16'($urandom);
			send_request(8'($urandom_range(1, 247)), fc, 16'($urandom), cnt);
		end
	endtask

	task automatic test_field_extremes();
		in_gap_pct = 0;
		out_stall_pct = 0;
		send_request(8'h00, 8'h00, 16'h0000, 16'h0000);
		send_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_request(8'h55, 8'hAA, 16'h55AA, 16'hAA55);
		send_request(8'hAA, 8'h55, 16'hAA55, 16'h55AA);
		send_request(8'h80, 8'h01, 16'h8000, 16'h0001);
		send_request(8'h01, 8'h80, 16'h0001, 16'h8000);
	endtask

	task automatic test_function_codes();
		in_gap_pct = 30;
		out_stall_pct = 30;
		// well-known read frame: 01 03 00 00 00 0a c5 cd
		send_request(8'h01, FC_READ_HOLDING, 16'h0000, 16'h000A);
		send_request(8'h11, FC_WRITE_SINGLE, 16'h0001, 16'h0003);
		send_request(8'hF7, FC_READ_HOLDING, 16'hFFFF, 16'h007D);
		send_request(8'h00, FC_WRITE_SINGLE, 16'h1234, 16'hFFFF);
		// codes outside read and write are framed like any other
		send_request(8'h02, 8'h10, 16'h0100, 16'h0002);
		send_request(8'h03, 8'h83, 16'h0000, 16'h0000);
		send_request(8'h04, 8'h00, 16'hBEEF, 16'hCAFE);
	endtask

	task automatic test_back_to_back();
		in_gap_pct = 0;
		out_stall_pct = 0;
		repeat (5) send_random_request(1'b1);
	endtask

	task automatic test_output_backpressure();
		// heavy stall lets the crc pipeline fill until the input stalls
		in_gap_pct = 0;
		out_stall_pct = 90;
		repeat (7) send_random_request(1'b1);
	endtask

	task automatic test_random_requests();
		for (int i = 0; i < 75; i++) begin
			if (i % 25 == 0) begin
				in_gap_pct = $urandom_range(0, 3) * 25;
				out_stall_pct = $urandom_range(0, 3) * 25;
			end
			send_random_request($urandom_range(0, 99) < 80);
		end
	endtask

	// output side: random stall bursts
	always @(posedge clk) begin
		if (stall_left == 0)
			stall_left = pick_gap(out_stall_pct);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// sampled mid-cycle, so an item seen here is taken at the next rising edge
	always begin
		tx_item_t want;
		@(negedge clk);
		if (arst_n && out_valid && !out_stall) begin
			if (frame_bytes_q.size() == 0) begin
				report_mismatch("unexpected tx_byte", int'(tx_byte), 0);
			end else begin
				want = frame_bytes_q.pop_front();
				if (tx_byte !== want.data)
					report_mismatch("tx_byte", int'(tx_byte), int'(want.data));
				if (last_byte !== want.last)
					report_mismatch("last_byte", int'(last_byte), int'(want.last));
			end
		end
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int guard;
		errors = 0;
		stall_left = 0;
		in_gap_pct = 0;
		out_stall_pct = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		out_stall <= 1'b0;
		slave_address <= 8'h00;
		function_code <= 8'h00;
		register_address <= 16'h0000;
		count_or_value <= 16'h0000;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_function_codes();
		test_back_to_back();
		test_output_backpressure();
		test_random_requests();
		in_valid <= 1'b0;

		guard = 0;
		while (frame_bytes_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (frame_bytes_q.size() != 0)
			report_mismatch("bytes never sent", frame_bytes_q.size(), 0);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
